@@ hw/rtl/urld_pkg.sv @@
// Shared types, character codes and hex helpers for the URL percent decoder.
// No dependencies; used by every module of the decoder.
`default_nettype none

package urld_pkg;

  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_PERCENT   = 8'h25;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_DIGIT_0   = 8'h30;
  localparam logic [7:0] CH_DIGIT_9   = 8'h39;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_UPPER_F   = 8'h46;
  localparam logic [7:0] CH_LOWER_A   = 8'h61;
  localparam logic [7:0] CH_LOWER_F   = 8'h66;
  localparam logic [7:0] HEX_ALPHA_BASE = 8'd10;

  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_PCT   = 2'd1;
  localparam logic [1:0] PEND_DIGIT = 2'd2;

  localparam logic [1:0] JOB_MAX = 2'd3;

  typedef struct packed {
    logic [1:0]      cnt;
    logic            last;
    logic [2:0][7:0] data;
  } job_t;

  typedef struct packed {
    logic [1:0] pend;
    logic [7:0] held;
  } front_stat_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) ||
           (c >= CH_UPPER_A && c <= CH_UPPER_F) ||
           (c >= CH_LOWER_A && c <= CH_LOWER_F);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
      v = c - CH_DIGIT_0;
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      v = c - CH_UPPER_A + HEX_ALPHA_BASE;
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      v = c - CH_LOWER_A + HEX_ALPHA_BASE;
    end
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/urld_front.sv @@
// Front end of the URL percent decoder: accepts input words, tracks a held
// escape and builds a job of up to three output bytes. Uses urld_pkg.
`default_nettype none

module urld_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_byte,
  input  wire logic                  in_last,
  input  wire logic                  q_full,
  output logic                       push,
  output urld_pkg::job_t             job,
  output urld_pkg::front_stat_t      stat
);

  logic [1:0] pend;
  logic [1:0] pend_next;
  logic [7:0] held;
  logic [7:0] held_next;
  logic       accept;
  logic       hex;
  logic       f_emit;
  logic [7:0] f_byte;
  logic [1:0] f_pend;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign hex      = urld_pkg::is_hex(in_byte);

  // handling of a byte with nothing held
  assign f_emit = (in_byte != urld_pkg::CH_PERCENT) || in_last;
  assign f_byte = (in_byte == urld_pkg::CH_PLUS) ? urld_pkg::CH_SPACE : in_byte;
  assign f_pend = (in_byte == urld_pkg::CH_PERCENT && !in_last) ?
                  urld_pkg::PEND_PCT : urld_pkg::PEND_NONE;

  always_comb begin
    job       = '0;
    job.last  = in_last;
    pend_next = urld_pkg::PEND_NONE;
    held_next = 8'd0;
    case (pend)
      urld_pkg::PEND_PCT: begin
        if (hex) begin
          if (in_last) begin
            job.cnt     = 2'd2;
            job.data[0] = urld_pkg::CH_PERCENT;
            job.data[1] = in_byte;
          end else begin
            pend_next = urld_pkg::PEND_DIGIT;
            held_next = in_byte;
          end
        end else begin
          job.cnt     = 2'd1 + {1'b0, f_emit};
          job.data[0] = urld_pkg::CH_PERCENT;
          job.data[1] = f_byte;
          pend_next   = f_pend;
        end
      end
      urld_pkg::PEND_DIGIT: begin
        if (hex) begin
          job.cnt     = 2'd1;
          job.data[0] = {urld_pkg::hex_value(held), urld_pkg::hex_value(in_byte)};
        end else begin
          job.cnt     = 2'd2 + {1'b0, f_emit};
          job.data[0] = urld_pkg::CH_PERCENT;
          job.data[1] = held;
          job.data[2] = f_byte;
          pend_next   = f_pend;
        end
      end
      default: begin
        job.cnt     = {1'b0, f_emit};
        job.data[0] = f_byte;
        pend_next   = f_pend;
      end
    endcase
  end

  assign push      = accept && (job.cnt != 2'd0);
  assign stat.pend = pend;
  assign stat.held = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= urld_pkg::PEND_NONE;
      held <= 8'd0;
    end else if (accept) begin
      pend <= pend_next;
      held <= held_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/urld_queue.sv @@
// Job queue between the front and back ends of the URL percent decoder.
// Small register FIFO of jobs. Uses urld_pkg.
`default_nettype none

module urld_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire urld_pkg::job_t  wr_job,
  output logic                 full,
  output logic                 q_valid,
  output urld_pkg::job_t       head,
  input  wire logic            pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  urld_pkg::job_t slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_pop;

  assign full    = (count == CW'(DEPTH));
  assign q_valid = (count != '0);
  assign head    = slots[rd_ptr];
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/urld_back.sv @@
// Back end of the URL percent decoder: walks the bytes of the head job and
// presents one output word per cycle unless stalled. Uses urld_pkg.
`default_nettype none

module urld_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire urld_pkg::job_t  head,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_last
);

  logic [1:0] idx;
  logic       at_end;

  assign at_end    = (idx == head.cnt - 2'd1);
  assign out_valid = q_valid;
  assign out_byte  = (idx == urld_pkg::JOB_MAX) ? head.data[0] : head.data[idx];
  assign out_last  = head.last && at_end;
  assign pop       = out_valid && out_ready && at_end;

  // advance through the job, rewind when it leaves the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (out_valid && out_ready) begin
      idx <= at_end ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/url_percent_decoder.sv @@
// Top level of the URL percent decoder: front end, job queue, back end.
// Depends on urld_pkg, urld_front, urld_queue and urld_back.
//
//   port group | dir | tdata         | tlast    | tuser
//   s_axis     | in  | [7:0] in_byte | in_last  | -
//   m_axis     | out | [7:0] out_byte| out_last | -
//
// One input word is taken per cycle while the job queue has room.
// Output words leave one per cycle while the output is ready; an escape
// cut short emits up to three words for one input word, so a burst of those
// can fill the queue briefly. Each job passes through a queue register.
// Synchronous active-high reset clears the held escape and empties the queue.
// Either side may stall; the queue of QUEUE_DEPTH jobs lets them run apart.
`default_nettype none

module url_percent_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  wire logic       s_axis_tlast,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic            m_axis_tlast
);

  logic                  q_full;
  logic                  push;
  urld_pkg::job_t        job;
  urld_pkg::front_stat_t stat;
  logic                  q_valid;
  urld_pkg::job_t        head;
  logic                  pop;

  urld_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .q_full   (q_full),
    .push     (push),
    .job      (job),
    .stat     (stat)
  );

  urld_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_job  (job),
    .full    (q_full),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop)
  );

  urld_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

  a_push_nonempty: assert property (@(posedge clk) disable iff (rst)
    push |-> (job.cnt != 2'd0))
    else $error("empty job pushed");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> stat.pend == urld_pkg::PEND_NONE)
    else $error("escape still held after last word");

  a_held_digit: assert property (@(posedge clk) disable iff (rst)
    (stat.pend == urld_pkg::PEND_DIGIT) |-> urld_pkg::is_hex(stat.held))
    else $error("held digit is not hex");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid && (head.cnt != 2'd0))
    else $error("pop without a valid job");

endmodule

`default_nettype wire
